### rtl/dchps_pkg.sv
// Shared types and constants for the dual-channel haptic pulse scheduler.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package dchps_pkg;

   // request kinds carried on req_tuser
   localparam logic [1:0] REQ_ENQUEUE = 2'd0;
   localparam logic [1:0] REQ_TICK    = 2'd1;
   localparam logic [1:0] REQ_STOP    = 2'd2;

   // register index, decoded from csr_paddr[2]
   localparam logic REG_DRIVER_ENABLED = 1'b0;

   localparam int NUM_CHAN = 2;

   // req_tdata layout, lowest bit first: hand, intensity, duration, delay, elapsed
   typedef struct packed {
      logic [6:0]  pad;
      logic [15:0] elapsed_time;
      logic [15:0] start_delay;
      logic [15:0] pulse_duration;
      logic [7:0]  pulse_intensity;
      logic        hand;
   } req_data_type;

   // rsp_tdata layout, lowest bit first: hand, intensity, duration
   typedef struct packed {
      logic [6:0]  pad;
      logic [15:0] out_duration;
      logic [7:0]  out_intensity;
      logic        out_hand;
   } rsp_data_type;

   // one FIFO entry
   typedef struct packed {
      logic [7:0]  intensity;
      logic [15:0] duration;
      logic [15:0] delay;
   } entry_type;

   // one queued drive command
   typedef struct packed {
      logic        last;
      logic        hand;
      logic [7:0]  intensity;
      logic [15:0] duration;
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_LOAD = 3'b010,
      ST_CALC = 3'b100
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;   // input word taken this cycle
      logic calc;     // apply the tick to both channels
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic queue_empty;  // no drive command waiting
      logic tick_go;      // word on req is a tick and the driver is enabled
   } dp_status_type;

endpackage

`default_nettype wire

### rtl/dchps_ctrl.sv
// Sequencer of the pulse scheduler: accepts words and steps a tick through
// head read and update. Depends on dchps_pkg.
`default_nettype none

module dchps_ctrl
   import dchps_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  dp_status_type      status,
   output ctrl_cmd_type       cmd
);

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE) && status.queue_empty;
   assign cmd.accept = req_tvalid && req_tready;
   assign cmd.calc   = (state_ff == ST_CALC);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.accept && status.tick_go) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_tick_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && status.tick_go |=> state_ff == ST_LOAD)
      else $error("tick accepted without head read");
   a_load_to_calc: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |=> state_ff == ST_CALC)
      else $error("head read not followed by update");
   a_calc_to_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CALC |=> state_ff == ST_IDLE && !req_tready ||
                              state_ff == ST_IDLE && status.queue_empty)
      else $error("update not followed by idle");
`endif

endmodule

`default_nettype wire

### rtl/dchps_datapath.sv
// Datapath of the pulse scheduler: per-hand FIFO memories, pointers, busy
// timers and a two-entry result queue. Depends on dchps_pkg.
`default_nettype none

module dchps_datapath
   import dchps_pkg::*;
#(
   parameter int FIFO_DEPTH = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          enabled,
   input  ctrl_cmd_type       cmd,
   output dp_status_type      status,
   input  wire logic [63:0]   req_tdata,
   input  wire logic [1:0]    req_tuser,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [31:0]        rsp_tdata,
   output logic               rsp_tlast
);

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

   req_data_type req;
   logic [1:0]   kind;

   logic [PTR_W-1:0] head_ff [NUM_CHAN];
   logic [PTR_W-1:0] head_in [NUM_CHAN];
   logic [PTR_W-1:0] tail_ff [NUM_CHAN];
   logic [PTR_W-1:0] tail_in [NUM_CHAN];
   logic [CNT_W-1:0] cnt_ff  [NUM_CHAN];
   logic [CNT_W-1:0] cnt_in  [NUM_CHAN];
   logic [15:0]      busy_ff [NUM_CHAN];
   logic [15:0]      busy_in [NUM_CHAN];
   logic [15:0]      busy_dec[NUM_CHAN];
   logic             idle    [NUM_CHAN];
   logic             fire    [NUM_CHAN];
   entry_type        rd_ff   [NUM_CHAN];
   logic             wr_en   [NUM_CHAN];
   logic [PTR_W-1:0] wr_addr [NUM_CHAN];
   entry_type        wr_data [NUM_CHAN];
   logic [15:0]      dt_ff;

   result_type       slot_ff[2];
   result_type       slot_in[2];
   logic [1:0]       qcnt_ff, qcnt_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   assign req  = req_data_type'(req_tdata);
   assign kind = req_tuser;

   assign status.queue_empty = (qcnt_ff == 2'd0);
   assign status.tick_go     = (kind == REQ_TICK) && enabled;

   // saturating busy countdown and fire decision per hand
   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         busy_dec[c] = (busy_ff[c] > dt_ff) ? busy_ff[c] - dt_ff : 16'd0;
         idle[c]     = (busy_dec[c] == 16'd0) && (cnt_ff[c] != '0);
         fire[c]     = cmd.calc && idle[c] && (rd_ff[c].delay <= dt_ff);
      end
   end

   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         head_in[c] = head_ff[c];
         tail_in[c] = tail_ff[c];
         cnt_in[c]  = cnt_ff[c];
         busy_in[c] = busy_ff[c];
         wr_en[c]   = 1'b0;
         wr_addr[c] = tail_ff[c];
         wr_data[c] = '{intensity: req.pulse_intensity,
                        duration:  req.pulse_duration,
                        delay:     req.start_delay};
         if (cmd.accept) begin
            case (kind)
               REQ_ENQUEUE: begin
                  // full FIFO drops the entry
                  if ((req.hand == 1'(c)) && (cnt_ff[c] != CNT_FULL)) begin
                     wr_en[c]   = 1'b1;
                     tail_in[c] = ptr_next(tail_ff[c]);
                     cnt_in[c]  = cnt_ff[c] + 1'b1;
                  end
               end
               REQ_STOP: begin
                  head_in[c] = '0;
                  tail_in[c] = '0;
                  cnt_in[c]  = '0;
                  busy_in[c] = 16'd0;
               end
               default: begin
               end
            endcase
         end
         if (cmd.calc) begin
            busy_in[c] = busy_dec[c];
            if (fire[c]) begin
               busy_in[c] = rd_ff[c].duration;
               head_in[c] = ptr_next(head_ff[c]);
               cnt_in[c]  = cnt_ff[c] - 1'b1;
            end else if (idle[c]) begin
               // front entry keeps waiting: write back the shorter delay
               wr_en[c]   = 1'b1;
               wr_addr[c] = head_ff[c];
               wr_data[c] = '{intensity: rd_ff[c].intensity,
                              duration:  rd_ff[c].duration,
                              delay:     rd_ff[c].delay - dt_ff};
            end
         end
      end
   end

   // result queue: slot 0 is the word on rsp
   always_comb begin
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      qcnt_in    = qcnt_ff;
      if (rsp_tvalid && rsp_tready) begin
         slot_in[0] = slot_ff[1];
         qcnt_in    = qcnt_ff - 2'd1;
      end
      if (cmd.accept && (kind == REQ_STOP) && enabled) begin
         slot_in[0] = '{last: 1'b0, hand: 1'b0, intensity: 8'd0, duration: 16'd0};
         slot_in[1] = '{last: 1'b1, hand: 1'b1, intensity: 8'd0, duration: 16'd0};
         qcnt_in    = 2'd2;
      end
      if (cmd.calc) begin
         slot_in[0] = fire[0] ?
            '{last: !fire[1], hand: 1'b0, intensity: rd_ff[0].intensity,
              duration: rd_ff[0].duration} :
            '{last: 1'b1, hand: 1'b1, intensity: rd_ff[1].intensity,
              duration: rd_ff[1].duration};
         slot_in[1] = '{last: 1'b1, hand: 1'b1, intensity: rd_ff[1].intensity,
                        duration: rd_ff[1].duration};
         qcnt_in    = 2'(fire[0]) + 2'(fire[1]);
      end
   end

   assign rsp_tvalid = (qcnt_ff != 2'd0);
   assign rsp_tlast  = slot_ff[0].last;
   assign rsp_tdata  = rsp_data_type'{pad:           '0,
                                      out_duration:  slot_ff[0].duration,
                                      out_intensity: slot_ff[0].intensity,
                                      out_hand:      slot_ff[0].hand};

   // one pulse memory per hand, head entry read every cycle
   for (genvar g = 0; g < NUM_CHAN; g++) begin : g_chan
      entry_type mem [FIFO_DEPTH];

      always_ff @(posedge clock) begin
         if (wr_en[g]) begin
            mem[wr_addr[g]] <= wr_data[g];
         end
         rd_ff[g] <= mem[head_ff[g]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CHAN; c++) begin
            head_ff[c] <= '0;
            tail_ff[c] <= '0;
            cnt_ff[c]  <= '0;
            busy_ff[c] <= 16'd0;
         end
         qcnt_ff <= 2'd0;
      end else begin
         for (int c = 0; c < NUM_CHAN; c++) begin
            head_ff[c] <= head_in[c];
            tail_ff[c] <= tail_in[c];
            cnt_ff[c]  <= cnt_in[c];
            busy_ff[c] <= busy_in[c];
         end
         qcnt_ff <= qcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         dt_ff <= req.elapsed_time;
      end
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
   end

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff[0] <= CNT_FULL && cnt_ff[1] <= CNT_FULL)
      else $error("fifo count beyond depth");
   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && kind == REQ_STOP |=>
         cnt_ff[0] == '0 && cnt_ff[1] == '0 && busy_ff[0] == 16'd0 && busy_ff[1] == 16'd0)
      else $error("stop left state behind");
   a_fire_loads_busy: assert property (@(posedge clock) disable iff (reset)
      fire[0] |=> busy_ff[0] == $past(rd_ff[0].duration))
      else $error("left busy timer not loaded on fire");
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      qcnt_ff <= 2'd2)
      else $error("result queue overflow");
`endif

endmodule

`default_nettype wire

### rtl/dual_channel_haptic_pulse_scheduler.sv
// Top level of the dual-channel haptic pulse scheduler: APB-style control
// register, sequencer and datapath. Depends on dchps_pkg, dchps_ctrl, dchps_datapath.
`default_nettype none

// Two-hand haptic pulse scheduler. Each hand has a FIFO of FIFO_DEPTH pulses
// (intensity, duration, start delay). req_tuser picks the request: enqueue
// pushes a pulse to the hand's FIFO (dropped when full, never answered), tick
// counts both busy timers down by elapsed_time (saturating at zero) and lets an
// idle hand count down its front pulse's delay; a pulse whose delay runs out is
// sent on rsp as a drive command, left before right, and its duration reloads
// the busy timer. Stop clears both FIFOs and timers and, when enabled, sends a
// zero drive for left then right. With driver_enabled at 0 ticks do nothing and
// stop sends nothing. rsp_tlast marks the final command caused by one word.
// Enqueue, stop, ignored kinds and ticks with the driver off end with their accept;
// a tick with the driver on goes through accept, a registered read of both FIFO
// heads from the pulse memories, and the update.
// The next word is taken once the up to two commands have been drained from
// the output queue, one per cycle while rsp_tready is high. No clearing pass is
// needed after reset. Register driver_enabled is at byte address 0, bit 0.

module dual_channel_haptic_pulse_scheduler
   import dchps_pkg::*;
#(
   parameter int FIFO_DEPTH = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   // request word
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [63:0]   req_tdata,   // hand, pulse_intensity, pulse_duration,
                                           // start_delay, elapsed_time, zero pad
   input  wire logic [1:0]    req_tuser,   // req_type
   // drive command word
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [31:0]        rsp_tdata,   // out_hand, out_intensity, out_duration, zero pad
   output logic               rsp_tlast,   // last_result
   // control register port
   input  wire logic          csr_psel,
   input  wire logic          csr_penable,
   input  wire logic          csr_pwrite,
   input  wire logic [2:0]    csr_paddr,
   input  wire logic [31:0]   csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          enabled_ff;
   logic          csr_wr;

   // register file: a single enable bit, word index in paddr[2]
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == REG_DRIVER_ENABLED);
   assign csr_prdata = (csr_paddr[2] == REG_DRIVER_ENABLED) ? {31'd0, enabled_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
      end else if (csr_wr) begin
         enabled_ff <= csr_pwdata[0];
      end
   end

   dchps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   dchps_datapath #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .enabled    (enabled_ff),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   a_no_accept_with_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while drive command pending");
   a_disabled_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !enabled_ff |=> !rsp_tvalid)
      else $error("drive command while disabled");
   a_enqueue_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == REQ_ENQUEUE |=> !rsp_tvalid)
      else $error("enqueue produced a drive command");
`endif

endmodule

`default_nettype wire
